/* src/rbd_pkg.sv */
// Package for the ring buffer deque: capacity, action and status codes,
// and the packed transaction types of both channels. No dependencies.
`timescale 1ns / 1ps

package rbd_pkg;

  // Capacity of the ring store in words.
  localparam int unsigned DEPTH = 64;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned OCC_W = 7;

  typedef enum logic [2:0] {
    ACT_PUSH_HEAD = 3'd0,
    ACT_PUSH_TAIL = 3'd1,
    ACT_POP_HEAD  = 3'd2,
    ACT_POP_TAIL  = 3'd3,
    ACT_CLEAR     = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] push_value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] pop_value;
    logic [1:0]         status;
    logic [OCC_W-1:0]   occupancy;
  } out_t;

endpackage

/* src/ring_buffer_deque_core.sv */
// Top level of the ring buffer deque: pointer and count logic, the ring
// store memory and the result stages. Depends on rbd_pkg.
`timescale 1ns / 1ps

// The block is a double-ended queue of signed 32-bit words held in a
// synchronous ring store of rbd_pkg::DEPTH words. Each input transaction
// pushes at the head or tail, pops from the head or tail, or clears the
// queue, and gives exactly one output transaction with the popped word, a
// status and the new occupancy. The pointers and the count are updated at
// the edge that accepts a transaction, and the store is written or read at
// that same edge. The read data is registered at that edge while the
// transaction moves into the pending stage; the output register loads from
// the pending stage when it is free or being emptied, and out_valid_o rises
// as it loads. A new input transaction can be accepted in every cycle as
// long as the output side takes results, which gives a sustained rate of
// one transaction per cycle; the single pending stage behind the store's
// registered read port sets that figure, and a stalled output holds the
// input side after at most two transactions are in flight. A push followed
// at once by a pop of the same entry needs no forwarding, since the write
// lands at the earlier edge. The store has no reset; only pointers, count
// and valid flags are cleared.

module ring_buffer_deque_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rbd_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rbd_pkg::out_t out_data_o
);

  localparam int unsigned PtrW = rbd_pkg::PTR_W;
  localparam int unsigned CntW = rbd_pkg::CNT_W;
  localparam logic [PtrW-1:0] LastPtr = PtrW'(rbd_pkg::DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(rbd_pkg::DEPTH);

  // Queue state.
  logic [PtrW-1:0] head_q, head_d;
  logic [PtrW-1:0] tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;

  // Ring store and its registered read port.
  logic signed [31:0] mem [rbd_pkg::DEPTH];
  logic signed [31:0] rd_data_q;
  logic               mem_we;
  logic [PtrW-1:0]    mem_addr;

  // Pending stage: waits for the read data of the store.
  logic               pend_valid_q;
  logic               pend_pop_q, pend_pop_d;
  rbd_pkg::status_e   pend_status_q, pend_status_d;
  logic [CntW-1:0]    pend_count_q;

  // Output register.
  logic               out_valid_q;
  rbd_pkg::out_t      out_q;

  logic in_accept;
  logic pend_move;
  logic is_full;
  logic cnt_zero;
  logic [PtrW-1:0] head_back;
  logic [PtrW-1:0] head_fwd;
  logic [PtrW-1:0] tail_back;
  logic [PtrW-1:0] tail_fwd;

  // The pending result moves on whenever the output register is free or
  // is being emptied in this cycle.
  assign pend_move  = pend_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = pend_valid_q && !pend_move;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign is_full  = (count_q == FullCnt);
  assign cnt_zero = (count_q == '0);

  assign head_back = (head_q == '0) ? LastPtr : head_q - 1'b1;
  assign head_fwd  = (head_q == LastPtr) ? '0 : head_q + 1'b1;
  assign tail_back = (tail_q == '0) ? LastPtr : tail_q - 1'b1;
  assign tail_fwd  = (tail_q == LastPtr) ? '0 : tail_q + 1'b1;

  // Action decode: next pointers, count, store access and status.
  always_comb begin
    head_d        = head_q;
    tail_d        = tail_q;
    count_d       = count_q;
    mem_we        = 1'b0;
    mem_addr      = head_q;
    pend_pop_d    = 1'b0;
    pend_status_d = rbd_pkg::ST_OK;
    case (in_data_i.action)
      rbd_pkg::ACT_PUSH_HEAD: begin
        if (is_full) begin
          pend_status_d = rbd_pkg::ST_OVERFLOW;
        end else begin
          head_d   = head_back;
          mem_addr = head_back;
          mem_we   = 1'b1;
          count_d  = count_q + 1'b1;
        end
      end
      rbd_pkg::ACT_PUSH_TAIL: begin
        if (is_full) begin
          pend_status_d = rbd_pkg::ST_OVERFLOW;
        end else begin
          mem_addr = tail_q;
          mem_we   = 1'b1;
          tail_d   = tail_fwd;
          count_d  = count_q + 1'b1;
        end
      end
      rbd_pkg::ACT_POP_HEAD: begin
        if (cnt_zero) begin
          pend_status_d = rbd_pkg::ST_UNDERFLOW;
        end else begin
          mem_addr   = head_q;
          pend_pop_d = 1'b1;
          head_d     = head_fwd;
          count_d    = count_q - 1'b1;
        end
      end
      rbd_pkg::ACT_POP_TAIL: begin
        if (cnt_zero) begin
          pend_status_d = rbd_pkg::ST_UNDERFLOW;
        end else begin
          tail_d     = tail_back;
          mem_addr   = tail_back;
          pend_pop_d = 1'b1;
          count_d    = count_q - 1'b1;
        end
      end
      rbd_pkg::ACT_CLEAR: begin
        head_d  = '0;
        tail_d  = '0;
        count_d = '0;
      end
      default: begin
        // Unused action codes leave the queue untouched.
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else if (in_accept) begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // Synchronous store: write on an accepted push, read every accepted
  // transaction; only pops use the read data.
  always_ff @(posedge clk_i) begin
    if (in_accept && mem_we) begin
      mem[mem_addr] <= in_data_i.push_value;
    end
    if (in_accept) begin
      rd_data_q <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (in_accept) begin
      pend_valid_q <= 1'b1;
    end else if (pend_move) begin
      pend_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pend_pop_q    <= pend_pop_d;
      pend_status_q <= pend_status_d;
      pend_count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pend_move) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_move) begin
      out_q.pop_value <= pend_pop_q ? rd_data_q : 32'sd0;
      out_q.status    <= pend_status_q;
      out_q.occupancy <= rbd_pkg::OCC_W'(pend_count_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The occupancy never goes beyond the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("word count exceeds capacity");

  // An empty queue always has its pointers together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (head_q == tail_q))
    else $error("empty queue with head and tail apart");

  // An accepted transaction is waiting in the pending stage next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> pend_valid_q)
    else $error("accepted transaction lost before the pending stage");

  // Failed pushes and pops report a zero word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.status == rbd_pkg::ST_UNDERFLOW
                     || out_q.status == rbd_pkg::ST_OVERFLOW))
      |-> (out_q.pop_value == 32'sd0))
    else $error("nonzero word with an error status");

endmodule

/* tb/ring_buffer_deque_core_tb.sv */
// Self-checking testbench for ring_buffer_deque_core: directed and random
// deque transactions checked against a behavioral deque kept in the bench.
// Depends on rbd_pkg and the ring_buffer_deque_core RTL.
`timescale 1ns / 1ps

module ring_buffer_deque_core_tb;

  // The run is bounded by a cycle counter.
  localparam int unsigned LIMIT_CYCLES = 200000;
  // Extra cycles at the end catch any stray output transaction.
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned RANDOM_ITEMS = 850;

  // Action codes that the block must treat as no-ops.
  localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

  // Kinds of random phases. Fill and drain phases push the queue to full
  // and to empty so that overflow, underflow and pointer wrap are reached.
  typedef enum logic [1:0] {
    PH_FILL,
    PH_DRAIN,
    PH_MIXED,
    PH_NOISE
  } phase_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  rbd_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rbd_pkg::out_t out_data;

  // Transactions waiting to be driven, and results the deque should give.
  rbd_pkg::in_t  stim_items[$];
  rbd_pkg::out_t awaited_results[$];

  // Behavioral deque: ring store, pointers and occupancy.
  logic signed [31:0]        deque_store [rbd_pkg::DEPTH];
  logic [rbd_pkg::PTR_W-1:0] deque_head = '0;
  logic [rbd_pkg::PTR_W-1:0] deque_tail = '0;
  int unsigned               deque_count = 0;

  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 8;
  int unsigned gap_left = 0;
  int unsigned stall_run = 0;
  // Set at each rising edge when the input side took a transaction.
  logic        in_fire = 1'b0;

  ring_buffer_deque_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [rbd_pkg::PTR_W-1:0] ptr_fwd(logic [rbd_pkg::PTR_W-1:0] p);
    return (p == rbd_pkg::PTR_W'(rbd_pkg::DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [rbd_pkg::PTR_W-1:0] ptr_back(logic [rbd_pkg::PTR_W-1:0] p);
    return (p == '0) ? rbd_pkg::PTR_W'(rbd_pkg::DEPTH - 1) : p - 1'b1;
  endfunction

  // Applies one transaction to the behavioral deque and returns the result
  // that the block should produce for it.
  function automatic rbd_pkg::out_t deque_apply(rbd_pkg::in_t item);
    rbd_pkg::out_t res;
    res = '0;
    res.status = rbd_pkg::ST_OK;
    case (item.action)
      rbd_pkg::ACT_PUSH_HEAD: begin
        if (deque_count >= rbd_pkg::DEPTH) begin
          res.status = rbd_pkg::ST_OVERFLOW;
        end else begin
          deque_head = ptr_back(deque_head);
          deque_store[deque_head] = item.push_value;
          deque_count++;
        end
      end
      rbd_pkg::ACT_PUSH_TAIL: begin
        if (deque_count >= rbd_pkg::DEPTH) begin
          res.status = rbd_pkg::ST_OVERFLOW;
        end else begin
          deque_store[deque_tail] = item.push_value;
          deque_tail = ptr_fwd(deque_tail);
          deque_count++;
        end
      end
      rbd_pkg::ACT_POP_HEAD: begin
        if (deque_count == 0) begin
          res.status = rbd_pkg::ST_UNDERFLOW;
        end else begin
          res.pop_value = deque_store[deque_head];
          deque_head = ptr_fwd(deque_head);
          deque_count--;
        end
      end
      rbd_pkg::ACT_POP_TAIL: begin
        if (deque_count == 0) begin
          res.status = rbd_pkg::ST_UNDERFLOW;
        end else begin
          // The tail-side top sits one slot behind the tail pointer.
          deque_tail = ptr_back(deque_tail);
          res.pop_value = deque_store[deque_tail];
          deque_count--;
        end
      end
      rbd_pkg::ACT_CLEAR: begin
        // The store keeps its contents; only pointers and count go to zero.
        deque_head = '0;
        deque_tail = '0;
        deque_count = 0;
      end
      default: begin
        // Spare codes leave the deque untouched.
      end
    endcase
    res.occupancy = rbd_pkg::OCC_W'(deque_count);
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("result %0d: %s is 0x%0h, expected 0x%0h", results_seen, what, got, want);
  endtask

  task automatic add_item(logic [2:0] act, logic [31:0] word);
    rbd_pkg::in_t item;
    item.action = act;
    item.push_value = word;
    stim_items.push_back(item);
  endtask

  // Picks a push or a pop at random, either end, with the given share of
  // pushes in percent. A small share of clears is mixed in when asked.
  function automatic logic [2:0] pick_action(int unsigned push_pct, int unsigned clear_pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < clear_pct) begin
      return rbd_pkg::ACT_CLEAR;
    end else if (roll < clear_pct + push_pct) begin
      return $urandom_range(0, 1) ? rbd_pkg::ACT_PUSH_TAIL : rbd_pkg::ACT_PUSH_HEAD;
    end
    return $urandom_range(0, 1) ? rbd_pkg::ACT_POP_TAIL : rbd_pkg::ACT_POP_HEAD;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 15))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // Fills the transaction queue: a directed opening, then random phases.
  initial begin : stimulus
    int unsigned items_left;
    int unsigned phase_len;
    int unsigned n;
    phase_e      kind;
    logic [2:0]  act;

    // Pops on an empty queue give underflow from both ends.
    add_item(rbd_pkg::ACT_POP_HEAD, $urandom());
    add_item(rbd_pkg::ACT_POP_TAIL, $urandom());
    // Extreme words at both ends.
    add_item(rbd_pkg::ACT_PUSH_HEAD, 32'h7fff_ffff);
    add_item(rbd_pkg::ACT_PUSH_TAIL, 32'h8000_0000);
    add_item(rbd_pkg::ACT_PUSH_HEAD, 32'h0000_0000);
    add_item(rbd_pkg::ACT_PUSH_TAIL, 32'hffff_ffff);
    // Spare action codes on a non-empty queue must change nothing.
    for (act = ACT_SPARE_FIRST; act != 3'd0; act++) begin
      add_item(act, $urandom());
    end
    add_item(rbd_pkg::ACT_POP_TAIL, $urandom());
    add_item(rbd_pkg::ACT_POP_HEAD, $urandom());
    add_item(rbd_pkg::ACT_POP_HEAD, $urandom());
    // Popping the last word from the tail empties the queue.
    add_item(rbd_pkg::ACT_POP_TAIL, $urandom());
    // Popping the last word from the head empties the queue as well.
    add_item(rbd_pkg::ACT_PUSH_TAIL, 32'h1234_5678);
    add_item(rbd_pkg::ACT_POP_HEAD, $urandom());
    add_item(rbd_pkg::ACT_POP_HEAD, $urandom());
    // A word pushed at the head is the tail-side top of a one-word queue.
    add_item(rbd_pkg::ACT_PUSH_HEAD, 32'ha5a5_a5a5);
    add_item(rbd_pkg::ACT_POP_TAIL, $urandom());
    // Clear on a non-empty queue, then on an empty one.
    add_item(rbd_pkg::ACT_PUSH_TAIL, 32'h0000_0001);
    add_item(rbd_pkg::ACT_PUSH_HEAD, 32'h0000_0002);
    add_item(rbd_pkg::ACT_CLEAR, $urandom());
    add_item(rbd_pkg::ACT_POP_TAIL, $urandom());
    add_item(rbd_pkg::ACT_CLEAR, $urandom());

    // Random part: fill and drain phases alternate so that the queue goes
    // through full and empty again and again, with short mixed or noisy
    // phases in between.
    items_left = RANDOM_ITEMS;
    kind = PH_FILL;
    while (items_left > 0) begin
      if (kind == PH_FILL || kind == PH_DRAIN) begin
        phase_len = $urandom_range(60, 110);
      end else begin
        phase_len = $urandom_range(20, 50);
      end
      if (phase_len > items_left) begin
        phase_len = items_left;
      end
      for (n = 0; n < phase_len; n++) begin
        case (kind)
          PH_FILL:  act = pick_action(95, 0);
          PH_DRAIN: act = pick_action(5, 0);
          PH_MIXED: act = pick_action(49, 2);
          default:  act = 3'($urandom_range(0, 7));
        endcase
        add_item(act, pick_word());
      end
      items_left -= phase_len;
      case (kind)
        PH_FILL:  kind = PH_DRAIN;
        PH_DRAIN: kind = $urandom_range(0, 2) ? PH_MIXED : PH_NOISE;
        default:  kind = PH_FILL;
      endcase
    end
  end

  // Driver. It works at the falling edge, so the block sees stable inputs at
  // every rising edge. A stalled transaction is held unchanged; otherwise the
  // next one is taken from the queue, in bursts of random length separated
  // by random gaps. A gap of zero makes back-to-back bursts with no idling.
  always @(negedge clk) begin : driver
    logic         nxt_valid;
    rbd_pkg::in_t nxt_data;
    nxt_valid = in_valid;
    nxt_data  = in_data;
    if (rst_n && (!in_valid || in_fire)) begin
      nxt_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (stim_items.size() != 0) begin
        nxt_valid = 1'b1;
        nxt_data  = stim_items.pop_front();
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
    in_valid <= nxt_valid;
    in_data  <= nxt_data;
  end

  // Receiver stall pattern: stalled runs of random length alternate with
  // free runs; now and then a long free run lets the block stream.
  always @(negedge clk) begin : stall_pattern
    logic nxt_stall;
    nxt_stall = out_stall;
    if (rst_n) begin
      if (stall_run > 0) begin
        stall_run--;
      end else if (out_stall) begin
        nxt_stall = 1'b0;
        stall_run = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 5);
      end else begin
        nxt_stall = 1'b1;
        stall_run = $urandom_range(0, 7);
      end
    end
    out_stall <= nxt_stall;
  end

  // Monitor. At each rising edge it checks an accepted output transaction
  // against the oldest awaited result, then predicts the result of an
  // accepted input transaction. Both are sampled before the block's own
  // updates at this edge take effect.
  always @(posedge clk) begin : monitor
    rbd_pkg::out_t want;
    if (!rst_n) begin
      in_fire = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected transaction, pop_value", out_data.pop_value, '0);
        end else begin
          want = awaited_results.pop_front();
          if (out_data.pop_value !== want.pop_value) begin
            report_mismatch("pop_value", out_data.pop_value, want.pop_value);
          end
          if (out_data.status !== want.status) begin
            report_mismatch("status", 32'(out_data.status), 32'(want.status));
          end
          if (out_data.occupancy !== want.occupancy) begin
            report_mismatch("occupancy", 32'(out_data.occupancy), 32'(want.occupancy));
          end
        end
        results_seen++;
      end
      in_fire = in_valid && !in_stall;
      if (in_fire) begin
        awaited_results.push_back(deque_apply(in_data));
      end
    end
  end

  // Watchdog on the length of the run.
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("[ring_buffer_deque_core] ERROR");
      $finish;
    end
  end

  // Reset, then wait until every transaction has been driven and every
  // awaited result has come back, let the drain period pass, and give the verdict.
  initial begin : sequencer
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    do begin
      @(posedge clk);
    end while (stim_items.size() != 0 || in_valid || awaited_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("[ring_buffer_deque_core] OK");
    end else begin
      $display("[ring_buffer_deque_core] ERROR");
    end
    $finish;
  end

endmodule
